@@ hdl/rcfa_pkg.sv @@
// ----------------------------------------------------------------------------
// rcfa_pkg
// Shared sizes, codes and types of the reference-counted frame allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcfa_pkg;

    localparam int MAX_FRAMES    = 1024;
    localparam int MAP_WORD_BITS = 32;
    localparam int REF_BITS      = 8;

    localparam int FRAME_W   = $clog2(MAX_FRAMES);
    localparam int COUNT_W   = FRAME_W + 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int WORD_W    = FRAME_W - BIT_W;
    localparam int MAP_WORDS = 1 << WORD_W;

    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic [MAP_WORD_BITS-1:0] map_word_t;
    typedef logic [FRAME_W-1:0]       frame_t;
    typedef logic [COUNT_W-1:0]       count_t;
    typedef logic [REF_BITS-1:0]      ref_t;
    typedef logic [WORD_W-1:0]        word_idx_t;
    typedef logic [BIT_W-1:0]         bit_idx_t;
    typedef logic [CMD_W-1:0]         cmd_t;
    typedef logic [STATUS_W-1:0]      status_t;

    // effective frame range [lo, hi) and its size
    typedef struct packed {
        count_t hi;
        count_t lo;
        count_t span;
    } bounds_t;

    localparam ref_t REF_MAX = '1;

    localparam cmd_t CMD_ALLOC   = 2'd0;
    localparam cmd_t CMD_ADDREF  = 2'd1;
    localparam cmd_t CMD_RELEASE = 2'd2;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_NOFREE = 2'd1;
    localparam status_t ST_BAD    = 2'd2;
    localparam status_t ST_COUNT  = 2'd3;

    localparam logic REG_TOTAL    = 1'b0;
    localparam logic REG_RESERVED = 1'b1;

    localparam count_t TOTAL_RESET    = COUNT_W'(MAX_FRAMES);
    localparam count_t RESERVED_RESET = '0;

endpackage

`default_nettype wire

@@ hdl/rcfa_cmd_if.sv @@
// ----------------------------------------------------------------------------
// rcfa_cmd_if
// Command channel: one allocator command per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rcfa_cmd_if import rcfa_pkg::*; ();

    logic   valid;
    logic   ready;
    cmd_t   command;
    frame_t frame_in;

    modport source (output valid, output command, output frame_in, input ready);
    modport sink   (input valid, input command, input frame_in, output ready);

endinterface

`default_nettype wire

@@ hdl/rcfa_res_if.sv @@
// ----------------------------------------------------------------------------
// rcfa_res_if
// Result channel: one result item per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rcfa_res_if import rcfa_pkg::*; ();

    logic    valid;
    logic    ready;
    frame_t  frame_out;
    status_t status;
    logic    became_free;
    ref_t    ref_after;
    count_t  free_count;

    modport source (
        output valid, output frame_out, output status, output became_free,
        output ref_after, output free_count, input ready
    );
    modport sink (
        input valid, input frame_out, input status, input became_free,
        input ref_after, input free_count, output ready
    );

endinterface

`default_nettype wire

@@ hdl/refcounted_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// refcounted_frame_allocator
// Page-frame allocator with a used bitmap and per-frame reference counts.
//
// Commands arrive one item at a time on the command channel and each gives
// exactly one result item. add_ref and release do one used-map read plus
// count read, then the update. For alloc, a per-word full summary picks the
// first candidate map word at or above the reserved boundary, and each
// candidate costs one map read; at most two candidates are probed (the
// partially reserved boundary word and the next non-full word). With no
// candidate left, the no-free answer comes straight from the summary. A new
// command is accepted once the current one has written its result register,
// even while that result still waits. Both memories come out of reset ready
// to use; no clearing pass is run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module refcounted_frame_allocator import rcfa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    rcfa_cmd_if.sink              cmd,
    rcfa_res_if.source            res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_CHECK  = 3'b100
    } state_t;

    typedef logic [WORD_W:0] word_pos_t;

    function automatic bit_idx_t low_bit(input map_word_t v);
        bit_idx_t idx;
        idx = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic word_idx_t low_word(input logic [MAP_WORDS-1:0] v);
        word_idx_t idx;
        idx = '0;
        for (int i = MAP_WORDS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = WORD_W'(i);
            end
        end
        return idx;
    endfunction

    bounds_t bounds;

    rcfa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bounds  (bounds)
    );

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg;
    frame_t                 frame_reg;
    word_pos_t              start_reg, start_next;
    word_idx_t              cand_reg, cand_next;
    logic [MAP_WORDS-1:0]   full_reg, full_next;
    logic [MAP_WORDS-1:0]   row_valid_reg;
    count_t                 alloc_count_reg, alloc_next;

    map_word_t              map_mem [MAP_WORDS];
    map_word_t              map_rdata_reg;
    logic                   map_rvalid_reg;
    ref_t                   ref_mem [MAX_FRAMES];
    ref_t                   ref_rdata_reg;

    logic                   map_re, map_we;
    word_idx_t              map_raddr, map_waddr;
    map_word_t              map_wdata;
    logic                   ref_re, ref_we;
    frame_t                 ref_raddr, ref_waddr;
    ref_t                   ref_wdata;

    logic                   res_valid_reg;
    frame_t                 res_frame_reg;
    status_t                res_status_reg;
    logic                   res_freed_reg;
    ref_t                   res_ref_reg;
    count_t                 res_free_reg;

    logic                   can_load, res_load, accept;
    frame_t                 frame_o;
    status_t                status_o;
    logic                   freed_o;
    ref_t                   ref_o;
    count_t                 free_o;

    word_pos_t              lo_w, hi_w, last_w;
    bit_idx_t               lo_b, hi_b;
    count_t                 hi_m1;
    logic [MAP_WORDS-1:0]   avail;
    word_idx_t              cand_w;
    logic                   no_cand;
    map_word_t              cur_word, lo_mask, hi_mask, free_bits, bit_sel;
    bit_idx_t               free_bit;
    logic                   frame_used, frame_in_range, op_ok;
    ref_t                   ref_dec;

    assign accept    = cmd.valid & cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign can_load  = !res_valid_reg || res.ready;

    assign lo_w  = bounds.lo[COUNT_W-1:BIT_W];
    assign lo_b  = bounds.lo[BIT_W-1:0];
    assign hi_w  = bounds.hi[COUNT_W-1:BIT_W];
    assign hi_b  = bounds.hi[BIT_W-1:0];
    assign hi_m1 = bounds.hi - COUNT_W'(1);
    assign last_w = hi_m1[COUNT_W-1:BIT_W];

    // candidate word: first not-full word at or above the search start
    assign avail   = ~full_reg & ({MAP_WORDS{1'b1}} << start_reg);
    assign cand_w  = low_word(avail);
    assign no_cand = (bounds.span == '0) || !(|avail) || ({1'b0, cand_w} > last_w);

    assign cur_word = map_rvalid_reg ? map_rdata_reg : '0;

    always_comb
    begin
        if ({1'b0, cand_reg} < lo_w)
        begin
            lo_mask = '0;
        end
        else if ({1'b0, cand_reg} == lo_w)
        begin
            lo_mask = {MAP_WORD_BITS{1'b1}} << lo_b;
        end
        else
        begin
            lo_mask = '1;
        end
        if ({1'b0, cand_reg} < hi_w)
        begin
            hi_mask = '1;
        end
        else if ({1'b0, cand_reg} == hi_w)
        begin
            hi_mask = ~({MAP_WORD_BITS{1'b1}} << hi_b);
        end
        else
        begin
            hi_mask = '0;
        end
    end

    assign free_bits = ~cur_word & lo_mask & hi_mask;
    assign free_bit  = low_bit(free_bits);

    assign bit_sel        = map_word_t'(1) << frame_reg[BIT_W-1:0];
    assign frame_used     = |(cur_word & bit_sel);
    assign frame_in_range = ({1'b0, frame_reg} >= bounds.lo) && ({1'b0, frame_reg} < bounds.hi);
    assign op_ok          = ((cmd_reg == CMD_ADDREF) || (cmd_reg == CMD_RELEASE))
                            && frame_in_range && frame_used;
    assign ref_dec        = ref_rdata_reg - ref_t'(1);

    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        cand_next  = cand_reg;
        map_re     = 1'b0;
        map_raddr  = '0;
        map_we     = 1'b0;
        map_waddr  = cand_reg;
        map_wdata  = cur_word;
        ref_re     = 1'b0;
        ref_raddr  = cmd.frame_in;
        ref_we     = 1'b0;
        ref_waddr  = frame_reg;
        ref_wdata  = ref_rdata_reg;
        res_load   = 1'b0;
        frame_o    = frame_reg;
        status_o   = ST_OK;
        freed_o    = 1'b0;
        ref_o      = '0;
        alloc_next = alloc_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.command == CMD_ALLOC)
                    begin
                        start_next = lo_w;
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        map_re     = 1'b1;
                        map_raddr  = cmd.frame_in[FRAME_W-1:BIT_W];
                        ref_re     = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_SEARCH:
            begin
                if (no_cand)
                begin
                    frame_o  = '0;
                    status_o = ST_NOFREE;
                    if (can_load)
                    begin
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    map_re     = 1'b1;
                    map_raddr  = cand_w;
                    cand_next  = cand_w;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (|free_bits)
                    begin
                        frame_o = {cand_reg, free_bit};
                        ref_o   = ref_t'(1);
                        if (can_load)
                        begin
                            res_load   = 1'b1;
                            map_we     = 1'b1;
                            map_wdata  = cur_word | (map_word_t'(1) << free_bit);
                            ref_we     = 1'b1;
                            ref_waddr  = {cand_reg, free_bit};
                            ref_wdata  = ref_t'(1);
                            alloc_next = alloc_count_reg + COUNT_W'(1);
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        start_next = {1'b0, cand_reg} + word_pos_t'(1);
                        state_next = S_SEARCH;
                    end
                end
                else if (!op_ok)
                begin
                    status_o = ST_BAD;
                    if (can_load)
                    begin
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (cmd_reg == CMD_ADDREF)
                begin
                    if (ref_rdata_reg == REF_MAX)
                    begin
                        status_o = ST_COUNT;
                        ref_o    = ref_rdata_reg;
                    end
                    else
                    begin
                        ref_o     = ref_rdata_reg + ref_t'(1);
                        ref_we    = can_load;
                        ref_wdata = ref_rdata_reg + ref_t'(1);
                    end
                    if (can_load)
                    begin
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    if (ref_rdata_reg == '0)
                    begin
                        status_o = ST_COUNT;
                    end
                    else
                    begin
                        ref_o     = ref_dec;
                        ref_we    = can_load;
                        ref_wdata = ref_dec;
                        if (ref_dec == '0)
                        begin
                            freed_o   = 1'b1;
                            map_we    = can_load;
                            map_waddr = frame_reg[FRAME_W-1:BIT_W];
                            map_wdata = cur_word & ~bit_sel;
                            if (can_load && (alloc_count_reg != '0))
                            begin
                                alloc_next = alloc_count_reg - COUNT_W'(1);
                            end
                        end
                    end
                    if (can_load)
                    begin
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        free_o = (bounds.span > alloc_next) ? (bounds.span - alloc_next) : '0;
    end

    always_comb
    begin
        full_next = full_reg;
        if (map_we)
        begin
            full_next[map_waddr] = &map_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            start_reg       <= '0;
            cand_reg        <= '0;
            full_reg        <= '0;
            row_valid_reg   <= '0;
            alloc_count_reg <= '0;
            map_rvalid_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            start_reg       <= start_next;
            cand_reg        <= cand_next;
            full_reg        <= full_next;
            alloc_count_reg <= alloc_next;
            if (map_we)
            begin
                row_valid_reg[map_waddr] <= 1'b1;
            end
            if (map_re)
            begin
                map_rvalid_reg <= row_valid_reg[map_raddr];
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd.command;
            frame_reg <= cmd.frame_in;
        end
        if (res_load)
        begin
            res_frame_reg  <= frame_o;
            res_status_reg <= status_o;
            res_freed_reg  <= freed_o;
            res_ref_reg    <= ref_o;
            res_free_reg   <= free_o;
        end
    end

    // used map: rows without a valid bit read as all free
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re)
        begin
            map_rdata_reg <= map_mem[map_raddr];
        end
    end

    // counts are only used for frames marked used, which alloc has written
    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_waddr] <= ref_wdata;
        end
        if (ref_re)
        begin
            ref_rdata_reg <= ref_mem[ref_raddr];
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.frame_out   = res_frame_reg;
    assign res.status      = res_status_reg;
    assign res.became_free = res_freed_reg;
    assign res.ref_after   = res_ref_reg;
    assign res.free_count  = res_free_reg;

`ifndef NO_ASSERTIONS
    a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (map_we || ref_we) |-> res_load)
        else $error("memory write without a result");

    a_full_tracks_map: assert property (@(posedge clk) disable iff (!rst_n)
        map_we |=> (full_reg[$past(map_waddr)] == (&$past(map_wdata))))
        else $error("full summary out of step with used map");

    a_alloc_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_count_reg <= COUNT_W'(MAX_FRAMES))
        else $error("allocated count beyond frame count");

    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && (cmd_reg == CMD_ALLOC) && (status_o == ST_OK))
        |-> (({1'b0, frame_o} >= bounds.lo) && ({1'b0, frame_o} < bounds.hi)))
        else $error("granted frame outside allocatable range");
`endif

endmodule

`default_nettype wire

@@ hdl/rcfa_regs.sv @@
// ----------------------------------------------------------------------------
// rcfa_regs
// APB register file for frame range; derives the effective allocatable range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcfa_regs import rcfa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output bounds_t               bounds
);

    count_t total_reg;
    count_t reserved_reg;
    logic   reg_sel;
    logic   wr_en;
    count_t hi;
    count_t lo;

    assign reg_sel = paddr[APB_ADDR_W-1];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= TOTAL_RESET;
            reserved_reg <= RESERVED_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_TOTAL)
            begin
                total_reg <= pwdata[COUNT_W-1:0];
            end
            else
            begin
                reserved_reg <= pwdata[COUNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == REG_TOTAL)
        begin
            prdata = APB_DATA_W'(total_reg);
        end
        else
        begin
            prdata = APB_DATA_W'(reserved_reg);
        end
    end

    // oversized totals clamp to the physical frame count
    assign hi = (total_reg > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES) : total_reg;
    assign lo = (reserved_reg > hi) ? hi : reserved_reg;

    assign bounds.hi   = hi;
    assign bounds.lo   = lo;
    assign bounds.span = hi - lo;

endmodule

`default_nettype wire

@@ tb/refcounted_frame_allocator_test.sv @@
// ----------------------------------------------------------------------------
// refcounted_frame_allocator_test
// Self-checking bench for the reference-counted page-frame allocator.
//
// A shadow allocator with its own used bits, counts and range registers
// predicts every response. A short table covers the directed cases: reset
// grants, bad and unused frames, an exhausted range, empty and oversized
// ranges. Random phases under several range settings follow, with refcount
// saturation, a long response hold-off and random gaps on both channels.
// Register writes happen only while the allocator is idle and are read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module refcounted_frame_allocator_test;

    import rcfa_pkg::*;

    localparam cmd_t CMD_UNUSED      = 2'd3;
    localparam int   HOLD_OFF_CYCLES = 300;
    localparam int   RANDOM_PER_PHASE = 140;
    localparam int   HAMMER_LEN      = 258;
    localparam int   NUM_PHASES      = 8;

    typedef struct packed {
        frame_t  frame;
        status_t status;
        logic    freed;
        ref_t    refc;
        count_t  left;
    } resp_t;

    typedef enum logic [1:0] {ROW_CMD, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        cmd_t      cmd;
        frame_t    frame;
        logic      reg_idx;
        int        value;
        bit        known;
        resp_t     resp;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    rcfa_cmd_if cmd_if ();
    rcfa_res_if res_if ();

    refcounted_frame_allocator u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow allocator
    bit    shadow_used [MAX_FRAMES];
    ref_t  shadow_refs [MAX_FRAMES];
    int    shadow_in_use;
    int    shadow_total;
    int    shadow_reserved;
    int    held_frames [$];
    int    last_grant;

    resp_t pending_responses [$];

    int  mismatches;
    int  items_sent;
    int  regs_written;
    int  status_seen [4];
    int  frees_seen;
    bit  src_gaps_on;
    bit  snk_gaps_on;
    bit  hold_off_req;

    dir_row_t dir_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(25, 60);
    endfunction

    function automatic dir_row_t row_op(input cmd_t c, input int f);
        dir_row_t d;
        d = '0;
        d.kind  = ROW_CMD;
        d.cmd   = c;
        d.frame = frame_t'(f);
        return d;
    endfunction

    function automatic dir_row_t row_known(input cmd_t c, input int f, input int ef,
                                           input status_t st, input logic fb,
                                           input int rc, input int left);
        dir_row_t d;
        d = row_op(c, f);
        d.known       = 1'b1;
        d.resp.frame  = frame_t'(ef);
        d.resp.status = st;
        d.resp.freed  = fb;
        d.resp.refc   = ref_t'(rc);
        d.resp.left   = count_t'(left);
        return d;
    endfunction

    function automatic dir_row_t row_reg(input logic idx, input int v);
        dir_row_t d;
        d = '0;
        d.kind    = ROW_REG;
        d.reg_idx = idx;
        d.value   = v;
        return d;
    endfunction

    task automatic note_mismatch(input string what, input int exp_v, input int got_v);
        if (mismatches < 10)
            $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
        mismatches++;
    endtask

    task automatic apply_command(input cmd_t c, input frame_t f, output resp_t r);
        int hi;
        int lo;
        int span;
        int i;
        int cnt;
        hi = (shadow_total > MAX_FRAMES) ? MAX_FRAMES : shadow_total;
        lo = (shadow_reserved > hi) ? hi : shadow_reserved;
        r = '0;
        r.frame  = f;
        r.status = ST_OK;
        if (c == CMD_ALLOC) begin
            r.frame = '0;
            i = lo;
            while (i < hi && shadow_used[i])
                i++;
            if (i < hi) begin
                shadow_used[i] = 1'b1;
                shadow_refs[i] = ref_t'(1);
                shadow_in_use++;
                held_frames.push_back(i);
                last_grant = i;
                r.frame = frame_t'(i);
                r.refc  = ref_t'(1);
            end
            else
                r.status = ST_NOFREE;
        end
        else if ((c == CMD_ADDREF || c == CMD_RELEASE) && int'(f) >= lo && int'(f) < hi &&
                 shadow_used[f]) begin
            cnt = shadow_refs[f];
            if (c == CMD_ADDREF) begin
                if (cnt >= int'(REF_MAX))
                    r.status = ST_COUNT;
                else begin
                    cnt++;
                    shadow_refs[f] = ref_t'(cnt);
                end
            end
            else if (cnt == 0)
                r.status = ST_COUNT;
            else begin
                cnt--;
                shadow_refs[f] = ref_t'(cnt);
                if (cnt == 0) begin
                    shadow_used[f] = 1'b0;
                    if (shadow_in_use > 0)
                        shadow_in_use--;
                    r.freed = 1'b1;
                    frees_seen++;
                    i = 0;
                    while (i < held_frames.size() && held_frames[i] != int'(f))
                        i++;
                    if (i < held_frames.size())
                        held_frames.delete(i);
                end
            end
            r.refc = ref_t'(cnt);
        end
        else
            r.status = ST_BAD;
        span   = hi - lo;
        r.left = count_t'((span > shadow_in_use) ? span - shadow_in_use : 0);
        status_seen[r.status]++;
    endtask

    task automatic send_command(input cmd_t c, input frame_t f, input bit known,
                                input resp_t known_resp);
        resp_t r;
        int    g;
        @(negedge clk);
        cmd_if.valid    <= 1'b1;
        cmd_if.command  <= c;
        cmd_if.frame_in <= f;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        apply_command(c, f, r);
        pending_responses.push_back(known ? known_resp : r);
        items_sent++;
        g = src_gaps_on ? gap_len() : 0;
        if (g > 0) begin
            @(negedge clk);
            cmd_if.valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_register(input logic idx, input int value);
        logic [APB_DATA_W-1:0] wd;
        logic [APB_DATA_W-1:0] rd;
        wd = $urandom();
        wd[COUNT_W-1:0] = value[COUNT_W-1:0];
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wd;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_TOTAL)
            shadow_total = value & 'h7FF;
        else
            shadow_reserved = value & 'h7FF;
        regs_written++;
        if (rd[COUNT_W-1:0] !== wd[COUNT_W-1:0])
            note_mismatch(idx == REG_TOTAL ? "readback total_frames" : "readback reserved_frames",
                          wd[COUNT_W-1:0], rd[COUNT_W-1:0]);
    endtask

    // response checker
    always @(posedge clk)
    begin
        resp_t e;
        if (rst_n && res_if.valid === 1'b1 && res_if.ready) begin
            if (pending_responses.size() == 0)
                note_mismatch("response with nothing outstanding", 0, 1);
            else begin
                e = pending_responses.pop_front();
                if (res_if.frame_out !== e.frame)
                    note_mismatch("frame_out", e.frame, res_if.frame_out);
                if (res_if.status !== e.status)
                    note_mismatch("status", e.status, res_if.status);
                if (res_if.became_free !== e.freed)
                    note_mismatch("became_free", e.freed, res_if.became_free);
                if (res_if.ref_after !== e.refc)
                    note_mismatch("ref_after", e.refc, res_if.ref_after);
                if (res_if.free_count !== e.left)
                    note_mismatch("free_count", e.left, res_if.free_count);
            end
        end
    end

    // response sink with random stalls and one long hold-off
    initial
    begin : result_sink
        int stall;
        int g;
        stall = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end
            else if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = HOLD_OFF_CYCLES - 1;
                res_if.ready <= 1'b0;
            end
            else begin
                g = snk_gaps_on ? gap_len() : 0;
                if (g > 0) begin
                    stall = g - 1;
                    res_if.ready <= 1'b0;
                end
                else
                    res_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int ph_total    [NUM_PHASES];
        int ph_reserved [NUM_PHASES];
        int ph_alloc    [NUM_PHASES];
        int t;
        int rv;
        int r;
        int k;
        int p;
        int g;
        cmd_t   c;
        frame_t f;

        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        cmd_if.valid    = 1'b0;
        cmd_if.command  = CMD_ALLOC;
        cmd_if.frame_in = '0;
        hold_off_req    = 1'b0;
        src_gaps_on     = 1'b1;
        snk_gaps_on     = 1'b1;
        mismatches      = 0;
        items_sent      = 0;
        regs_written    = 0;
        frees_seen      = 0;
        last_grant      = 0;
        shadow_in_use   = 0;
        shadow_total    = TOTAL_RESET;
        shadow_reserved = RESERVED_RESET;
        for (k = 0; k < 4; k++)
            status_seen[k] = 0;
        for (k = 0; k < MAX_FRAMES; k++) begin
            shadow_used[k] = 1'b0;
            shadow_refs[k] = '0;
        end

        ph_total    = '{1024, 40, 1024, 64, 300, -1, 2047, 1024};
        ph_reserved = '{0, 8, 1000, 63, 0, -1, 30, 0};
        ph_alloc    = '{40, 45, 35, 50, 30, 40, 40, 15};

        dir_rows.push_back(row_known(CMD_ALLOC, 0, 0, ST_OK, 1'b0, 1, 1023));
        dir_rows.push_back(row_known(CMD_ADDREF, 0, 0, ST_OK, 1'b0, 2, 1023));
        dir_rows.push_back(row_known(CMD_RELEASE, 0, 0, ST_OK, 1'b0, 1, 1023));
        dir_rows.push_back(row_known(CMD_RELEASE, 0, 0, ST_OK, 1'b1, 0, 1024));
        dir_rows.push_back(row_known(CMD_RELEASE, 0, 0, ST_BAD, 1'b0, 0, 1024));
        dir_rows.push_back(row_known(CMD_ADDREF, 1023, 1023, ST_BAD, 1'b0, 0, 1024));
        dir_rows.push_back(row_known(CMD_UNUSED, 1023, 1023, ST_BAD, 1'b0, 0, 1024));
        dir_rows.push_back(row_op(CMD_ALLOC, 1023));
        dir_rows.push_back(row_op(CMD_ALLOC, 0));
        dir_rows.push_back(row_reg(REG_TOTAL, 4));
        dir_rows.push_back(row_reg(REG_RESERVED, 2));
        dir_rows.push_back(row_op(CMD_ALLOC, 0));
        dir_rows.push_back(row_op(CMD_ALLOC, 0));
        dir_rows.push_back(row_known(CMD_ALLOC, 0, 0, ST_NOFREE, 1'b0, 0, 0));
        dir_rows.push_back(row_op(CMD_RELEASE, 1));
        dir_rows.push_back(row_op(CMD_ADDREF, 4));
        dir_rows.push_back(row_reg(REG_TOTAL, 0));
        dir_rows.push_back(row_known(CMD_ALLOC, 0, 0, ST_NOFREE, 1'b0, 0, 0));
        dir_rows.push_back(row_reg(REG_TOTAL, 2047));
        dir_rows.push_back(row_reg(REG_RESERVED, 2047));
        dir_rows.push_back(row_known(CMD_ALLOC, 0, 0, ST_NOFREE, 1'b0, 0, 0));
        dir_rows.push_back(row_op(CMD_RELEASE, 1023));
        dir_rows.push_back(row_reg(REG_RESERVED, 0));
        dir_rows.push_back(row_op(CMD_ALLOC, 0));
        for (k = 0; k < 5; k++)
            dir_rows.push_back(row_op(CMD_RELEASE, k));
        dir_rows.push_back(row_reg(REG_TOTAL, 1024));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                wait_idle();
                set_register(dir_rows[i].reg_idx, dir_rows[i].value);
            end
            else
                send_command(dir_rows[i].cmd, dir_rows[i].frame, dir_rows[i].known,
                             dir_rows[i].resp);
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            t  = ph_total[p];
            rv = ph_reserved[p];
            if (t < 0) begin
                t  = $urandom_range(0, 1024);
                rv = $urandom_range(0, t);
            end
            wait_idle();
            set_register(REG_TOTAL, t);
            set_register(REG_RESERVED, rv);
            src_gaps_on = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
            snk_gaps_on = ($urandom_range(0, 3) != 0);
            if (p == 0)
                hold_off_req = 1'b1;
            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                r = $urandom_range(0, 99);
                if (r < ph_alloc[p])
                    send_command(CMD_ALLOC, frame_t'($urandom_range(0, 1023)), 1'b0, '0);
                else if (r < 88 && held_frames.size() > 0) begin
                    g = held_frames[$urandom_range(0, held_frames.size() - 1)];
                    c = (r < (ph_alloc[p] + 88) / 2) ? CMD_ADDREF : CMD_RELEASE;
                    send_command(c, frame_t'(g), 1'b0, '0);
                end
                else begin
                    c = cmd_t'($urandom_range(0, 3));
                    f = frame_t'($urandom_range(0, 1023));
                    send_command(c, f, 1'b0, '0);
                end
            end
            if (p == 0) begin
                // drive one frame to saturation and back down past zero
                send_command(CMD_ALLOC, '0, 1'b0, '0);
                g = last_grant;
                repeat (HAMMER_LEN) send_command(CMD_ADDREF, frame_t'(g), 1'b0, '0);
                repeat (HAMMER_LEN) send_command(CMD_RELEASE, frame_t'(g), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);

        $display("Ran %0d commands over %0d register writes: %0d ok, %0d exhausted,",
                 items_sent, regs_written, status_seen[ST_OK], status_seen[ST_NOFREE]);
        $display("  %0d bad frame, %0d saturated, %0d frames freed, %0d mismatches",
                 status_seen[ST_BAD], status_seen[ST_COUNT], frees_seen, mismatches);
        if (mismatches == 0 && pending_responses.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
